// File: hw/rtl/qro_pkg.sv
// ----------------------------------------------------------------------------
// qro_pkg
// Shared widths, constants, command codes and an arithmetic helper for the
// quadrature rotation oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package qro_pkg;

   // Block length and sample counter
   localparam int SAMPLES_PER_BLOCK = 16;
   localparam int CNT_W = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SAMPLES_PER_BLOCK - 1);

   // Q2.16 sample, 19-bit multiplier operand (covers the scale factor),
   // product and sum widths
   localparam int VAL_W  = 18;
   localparam int OPD_W  = 19;
   localparam int PROD_W = 2 * OPD_W;
   localparam int SUM_W  = PROD_W + 1;

   localparam logic signed [VAL_W-1:0] ONE_Q16 = 18'sd65536;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 18'sd131071;
   localparam logic signed [VAL_W-1:0] VAL_MIN = -18'sd131072;

   // 3.0 in Q.32, i.e. 1.5 in Q.33; half an LSB of Q.16 at the shifts used
   localparam logic signed [SUM_W-1:0] THREE_Q32 = 39'sd12884901888;
   localparam logic signed [SUM_W-1:0] HALF_Q16  = 39'sd32768;
   localparam logic signed [SUM_W-1:0] HALF_Q17  = 39'sd65536;

   // Register map (word index)
   localparam logic REG_COS = 1'b0;
   localparam logic REG_SIN = 1'b1;

   // Datapath commands
   typedef logic [2:0] op_type;
   localparam op_type OP_HOLD  = 3'd0;
   localparam op_type OP_LOAD  = 3'd1;
   localparam op_type OP_ROT   = 3'd2;
   localparam op_type OP_POWER = 3'd3;
   localparam op_type OP_SCALE = 3'd4;
   localparam op_type OP_NORM  = 3'd5;

   typedef struct packed {
      op_type op;
   } qro_cmd_type;

   // Round half up from Q.32 to Q.16, then saturate to 18 bits
   function automatic logic signed [VAL_W-1:0] sat_rnd16(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = (v + HALF_Q16) >>> 16;
      if (!t[SUM_W-1] && (|t[SUM_W-2:VAL_W-1])) begin
         return VAL_MAX;
      end else if (t[SUM_W-1] && !(&t[SUM_W-2:VAL_W-1])) begin
         return VAL_MIN;
      end else begin
         return t[VAL_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qro_datapath.sv
// ----------------------------------------------------------------------------
// qro_datapath
// Sample and phasor registers, power and scale registers, and one shared set
// of four multipliers used for rotation, power and renormalisation.
// ----------------------------------------------------------------------------
`default_nettype none

module qro_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire qro_pkg::qro_cmd_type              cmd,
   input  wire logic signed [qro_pkg::VAL_W-1:0]  cos_coeff,
   input  wire logic signed [qro_pkg::VAL_W-1:0]  sin_coeff,
   output logic signed [qro_pkg::VAL_W-1:0]       sample_real,
   output logic signed [qro_pkg::VAL_W-1:0]       sample_imag
);
   import qro_pkg::*;

   // Current sample; holds the phasor between blocks
   logic signed [VAL_W-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [SUM_W-1:0] pwr_ff, pwr_in;
   logic signed [OPD_W-1:0] scale_ff, scale_in;

   logic signed [OPD_W-1:0]  a0, b0, a1, b1, a2, b2, a3, b3;
   logic signed [PROD_W-1:0] p0, p1, p2, p3;
   logic signed [SUM_W-1:0]  sum_re, sum_im, sum_pwr, scale_full;
   logic signed [OPD_W-1:0]  re_x, im_x, cos_x, sin_x;

   assign re_x  = OPD_W'(re_ff);
   assign im_x  = OPD_W'(im_ff);
   assign cos_x = OPD_W'(cos_coeff);
   assign sin_x = OPD_W'(sin_coeff);

   // Operand selection for the shared multipliers
   always_comb begin
      a0 = cos_x; b0 = re_x;
      a1 = sin_x; b1 = im_x;
      a2 = sin_x; b2 = re_x;
      a3 = cos_x; b3 = im_x;
      unique case (cmd.op)
         OP_POWER: begin
            a0 = re_x; b0 = re_x;
            a1 = im_x; b1 = im_x;
         end
         OP_NORM: begin
            a0 = scale_ff; b0 = re_x;
            a2 = scale_ff; b2 = im_x;
         end
         default: begin
         end
      endcase
   end

   assign p0 = a0 * b0;
   assign p1 = a1 * b1;
   assign p2 = a2 * b2;
   assign p3 = a3 * b3;

   // Rotation sums, or the plain scaled products when normalising
   always_comb begin
      if (cmd.op == OP_NORM) begin
         sum_re = SUM_W'(p0);
         sum_im = SUM_W'(p2);
      end else begin
         sum_re = SUM_W'(p0) - SUM_W'(p1);
         sum_im = SUM_W'(p2) + SUM_W'(p3);
      end
   end

   assign sum_pwr    = SUM_W'(p0) + SUM_W'(p1);
   assign scale_full = (THREE_Q32 - pwr_ff + HALF_Q17) >>> 17;

   // Register updates
   always_comb begin
      re_in    = re_ff;
      im_in    = im_ff;
      pwr_in   = pwr_ff;
      scale_in = scale_ff;
      unique case (cmd.op)
         OP_HOLD: begin
         end
         OP_LOAD: begin
            re_in = ONE_Q16;
            im_in = '0;
         end
         OP_ROT, OP_NORM: begin
            re_in = sat_rnd16(sum_re);
            im_in = sat_rnd16(sum_im);
         end
         OP_POWER: begin
            pwr_in = sum_pwr;
         end
         OP_SCALE: begin
            scale_in = scale_full[OPD_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         re_ff <= ONE_Q16;
         im_ff <= '0;
      end else begin
         re_ff <= re_in;
         im_ff <= im_in;
      end
   end

   always_ff @(posedge clock) begin
      pwr_ff   <= pwr_in;
      scale_ff <= scale_in;
   end

   assign sample_real = re_ff;
   assign sample_imag = im_ff;

endmodule

`default_nettype wire

// File: hw/rtl/qro_ctrl.sv
// ----------------------------------------------------------------------------
// qro_ctrl
// Sequencer: takes a request, steps the datapath through rotate, power,
// scale and normalise, then hands out the block one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module qro_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic           req_restart,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic                rsp_block_last,
   output qro_pkg::qro_cmd_type cmd
);
   import qro_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ROT   = 3'd1;
   localparam logic [2:0] S_POWER = 3'd2;
   localparam logic [2:0] S_SCALE = 3'd3;
   localparam logic [2:0] S_NORM  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             req_take, rsp_take, is_last;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_EMIT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign is_last   = (cnt_ff == LAST_CNT);
   assign rsp_block_last = is_last;

   // Next state, counter and datapath command
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_HOLD;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_ROT;
               if (req_restart) cmd.op = OP_LOAD;
            end
         end
         S_ROT: begin
            cmd.op   = OP_ROT;
            state_in = S_POWER;
         end
         S_POWER: begin
            cmd.op   = OP_POWER;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.op   = OP_SCALE;
            state_in = S_NORM;
         end
         S_NORM: begin
            cmd.op   = OP_NORM;
            cnt_in   = '0;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_take) begin
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.op = OP_ROT;
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/quadrature_rotation_oscillator.sv
// ----------------------------------------------------------------------------
// quadrature_rotation_oscillator
// Quadrature oscillator by complex rotation with a first-order magnitude
// correction on the first sample of each block.
// ----------------------------------------------------------------------------
// Each request beat yields SAMPLES_PER_BLOCK result beats (sample_real,
// sample_imag, Q2.16, saturated), the last flagged by block_last. A request
// with restart set reloads the phasor to (1.0, 0) first. A block runs rotate,
// power, scale and renormalise in turn through the one shared multiplier set,
// then hands out one sample per cycle while rsp_stall is low, each rotated
// from the one before it. One block is in flight at a time; requests stall
// until the last beat of the previous block is taken. cos_coeff (offset 0x0,
// reset 1.0) and sin_coeff (offset 0x4, reset 0) are to be written from
// software while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_rotation_oscillator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_restart,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [qro_pkg::VAL_W-1:0]       rsp_sample_real,
   output logic signed [qro_pkg::VAL_W-1:0]       rsp_sample_imag,
   output logic                                   rsp_block_last,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [2:0]                        csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import qro_pkg::*;

   logic signed [VAL_W-1:0] cos_ff, cos_in, sin_ff, sin_in;
   logic                    csr_wr;
   qro_cmd_type             cmd;

   // Register port: word index from paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cos_in = cos_ff;
      sin_in = sin_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_COS: cos_in = csr_pwdata[VAL_W-1:0];
            REG_SIN: sin_in = csr_pwdata[VAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_ff <= ONE_Q16;
         sin_ff <= '0;
      end else begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   // Read-back, sign-extended
   always_comb begin
      unique case (csr_paddr[2])
         REG_COS: csr_prdata = 32'(cos_ff);
         REG_SIN: csr_prdata = 32'(sin_ff);
         default: csr_prdata = '0;
      endcase
   end

   qro_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_block_last (rsp_block_last),
      .cmd            (cmd)
   );

   qro_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .cos_coeff   (cos_ff),
      .sin_coeff   (sin_ff),
      .sample_real (rsp_sample_real),
      .sample_imag (rsp_sample_imag)
   );

   // Checks
   a_no_req_while_emitting: assert property (
      @(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("request taken while a block is being emitted");

   a_req_no_immediate_rsp: assert property (
      @(posedge clock) disable iff (reset) (req_valid && !req_stall) |=> !rsp_valid)
      else $error("result beat in the cycle after a request");

   a_last_ends_block: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_block_last) |=> (!rsp_valid && !req_stall))
      else $error("block did not end after its last beat");

   a_sample_held_on_stall: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_sample_real) && $stable(rsp_sample_imag)))
      else $error("sample changed while stalled");

endmodule

`default_nettype wire
